// ===== src/rot_pkg.sv =====
// Shared constants, configuration types and register indexes for the rotation address map.
package rot_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int MAX_DIM    = 4096;
  localparam int DIM_W      = 13;
  localparam int ANG_W      = 16;
  localparam int COORD_W    = 13;
  localparam int ADDR_W     = 12;
  localparam int EXT_W      = 14;
  localparam int EXT_MAX    = 2**EXT_W - 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // corner products, box bounds and back-mapped base points
  localparam int PROD_W     = DIM_W + 1 + ANG_W;
  localparam int CRN_W      = PROD_W + 1;
  // mapped point in Q.(2*FRAC_BITS)
  localparam int MAP_PROD_W = CRN_W + ANG_W;
  localparam int SUM_W      = MAP_PROD_W + 1;
  localparam int PT_W       = SUM_W - 2 * FRAC_BITS;

  localparam int IN_TDATA_W  = ((2 * COORD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 2 * ADDR_W + 2 * EXT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS    = 2'd0,
    CFG_SIN    = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ANG_W-1:0] cos_angle;
    logic [ANG_W-1:0] sin_angle;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic [CRN_W-1:0] bx;
    logic [CRN_W-1:0] by;
    logic [EXT_W-1:0] out_width;
    logic [EXT_W-1:0] out_height;
  } box_t;

endpackage

// ===== src/rot_box.sv =====
// Bounding box of the rotated source and destination-to-base-point offset, four stages.
module rot_box (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rot_pkg::cfg_t                     cfg_i,
  input  logic                              s_valid_i,
  output logic                              s_ready_o,
  input  logic [rot_pkg::COORD_W-1:0]       dst_row_i,
  input  logic [rot_pkg::COORD_W-1:0]       dst_col_i,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output rot_pkg::box_t                     m_box_o
);

  localparam int XW = rot_pkg::CRN_W - rot_pkg::FRAC_BITS;

  logic [3:0] v_q;
  logic [3:0] rdy;

  logic signed [rot_pkg::DIM_W:0]   w_s, h_s;
  logic signed [rot_pkg::ANG_W-1:0] cos_s, sin_s;

  // stage 1: corner products
  logic [rot_pkg::COORD_W-1:0]       row1_q, col1_q;
  logic signed [rot_pkg::PROD_W-1:0] wc_d, ws_d, hs_d, hc_d;
  logic signed [rot_pkg::PROD_W-1:0] wc_q, ws_q, hs_q, hc_q;
  // stage 2: corners
  logic [rot_pkg::COORD_W-1:0]      row2_q, col2_q;
  logic signed [rot_pkg::CRN_W-1:0] a1_d, a2_d, a3_d, b1_d, b2_d, b3_d;
  logic signed [rot_pkg::CRN_W-1:0] a1_q, a2_q, a3_q, b1_q, b2_q, b3_q;
  // stage 3: box bounds
  logic [rot_pkg::COORD_W-1:0]      row3_q, col3_q;
  logic signed [rot_pkg::CRN_W-1:0] kx_min_d, kx_max_d, ky_min_d, ky_max_d;
  logic signed [rot_pkg::CRN_W-1:0] kx_min_q, kx_max_q, ky_min_q, ky_max_q;
  // stage 4: base point and extents
  logic signed [rot_pkg::CRN_W-1:0] col_sh, row_sh;
  logic [rot_pkg::CRN_W-1:0]        dx, dy;
  logic [XW-1:0]                    xw, yw;
  rot_pkg::box_t                    box_d, box_q;

  function automatic logic signed [rot_pkg::CRN_W-1:0] min4(
    input logic signed [rot_pkg::CRN_W-1:0] p,
    input logic signed [rot_pkg::CRN_W-1:0] q,
    input logic signed [rot_pkg::CRN_W-1:0] r,
    input logic signed [rot_pkg::CRN_W-1:0] t
  );
    logic signed [rot_pkg::CRN_W-1:0] m;
    m = p;
    if (q < m) m = q;
    if (r < m) m = r;
    if (t < m) m = t;
    return m;
  endfunction

  function automatic logic signed [rot_pkg::CRN_W-1:0] max4(
    input logic signed [rot_pkg::CRN_W-1:0] p,
    input logic signed [rot_pkg::CRN_W-1:0] q,
    input logic signed [rot_pkg::CRN_W-1:0] r,
    input logic signed [rot_pkg::CRN_W-1:0] t
  );
    logic signed [rot_pkg::CRN_W-1:0] m;
    m = p;
    if (q > m) m = q;
    if (r > m) m = r;
    if (t > m) m = t;
    return m;
  endfunction

  function automatic logic [rot_pkg::EXT_W-1:0] sat_ext(input logic [XW-1:0] v);
    if (v > XW'(rot_pkg::EXT_MAX)) begin
      return rot_pkg::EXT_W'(rot_pkg::EXT_MAX);
    end
    return v[rot_pkg::EXT_W-1:0];
  endfunction

  // a stage takes a new request when empty or when its successor moves on
  assign rdy[3]    = !v_q[3] || m_ready_i;
  assign rdy[2]    = !v_q[2] || rdy[3];
  assign rdy[1]    = !v_q[1] || rdy[2];
  assign rdy[0]    = !v_q[0] || rdy[1];
  assign s_ready_o = rdy[0];
  assign m_valid_o = v_q[3];
  assign m_box_o   = box_q;

  assign w_s   = $signed({1'b0, cfg_i.width});
  assign h_s   = $signed({1'b0, cfg_i.height});
  assign cos_s = $signed(cfg_i.cos_angle);
  assign sin_s = $signed(cfg_i.sin_angle);

  always_comb begin
    wc_d = w_s * cos_s;
    ws_d = w_s * sin_s;
    hs_d = h_s * sin_s;
    hc_d = h_s * cos_s;
  end

  always_comb begin
    a1_d = rot_pkg::CRN_W'(wc_q);
    a2_d = rot_pkg::CRN_W'(wc_q) - rot_pkg::CRN_W'(hs_q);
    a3_d = -rot_pkg::CRN_W'(hs_q);
    b1_d = rot_pkg::CRN_W'(ws_q);
    b2_d = rot_pkg::CRN_W'(ws_q) + rot_pkg::CRN_W'(hc_q);
    b3_d = rot_pkg::CRN_W'(hc_q);
  end

  always_comb begin
    kx_min_d = min4('0, a1_q, a2_q, a3_q);
    kx_max_d = max4('0, a1_q, a2_q, a3_q);
    ky_min_d = min4('0, b1_q, b2_q, b3_q);
    ky_max_d = max4('0, b1_q, b2_q, b3_q);
  end

  always_comb begin
    col_sh = rot_pkg::CRN_W'($signed({1'b0, col3_q, {rot_pkg::FRAC_BITS{1'b0}}}));
    row_sh = rot_pkg::CRN_W'($signed({1'b0, row3_q, {rot_pkg::FRAC_BITS{1'b0}}}));
    // the extent is never negative, so a plain shift truncates it
    dx     = kx_max_q - kx_min_q;
    dy     = ky_max_q - ky_min_q;
    xw     = dx[rot_pkg::CRN_W-1:rot_pkg::FRAC_BITS];
    yw     = dy[rot_pkg::CRN_W-1:rot_pkg::FRAC_BITS];
    box_d.bx         = col_sh + kx_min_q;
    box_d.by         = row_sh + ky_min_q;
    box_d.out_width  = sat_ext(xw);
    box_d.out_height = sat_ext(yw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= s_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && s_valid_i) begin
      row1_q <= dst_row_i;
      col1_q <= dst_col_i;
      wc_q   <= wc_d;
      ws_q   <= ws_d;
      hs_q   <= hs_d;
      hc_q   <= hc_d;
    end
    if (rdy[1] && v_q[0]) begin
      row2_q <= row1_q;
      col2_q <= col1_q;
      a1_q   <= a1_d;
      a2_q   <= a2_d;
      a3_q   <= a3_d;
      b1_q   <= b1_d;
      b2_q   <= b2_d;
      b3_q   <= b3_d;
    end
    if (rdy[2] && v_q[1]) begin
      row3_q   <= row2_q;
      col3_q   <= col2_q;
      kx_min_q <= kx_min_d;
      kx_max_q <= kx_max_d;
      ky_min_q <= ky_min_d;
      ky_max_q <= ky_max_d;
    end
    if (rdy[3] && v_q[2]) begin
      box_q <= box_d;
    end
  end

endmodule

// ===== src/rot_map.sv =====
// Inverse rotation of the base point, truncation toward zero and source hit test, three stages.
module rot_map (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rot_pkg::cfg_t                 cfg_i,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  rot_pkg::box_t                 s_box_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [rot_pkg::ADDR_W-1:0]    src_row_o,
  output logic [rot_pkg::ADDR_W-1:0]    src_col_o,
  output logic                          hit_o,
  output logic [rot_pkg::EXT_W-1:0]     out_width_o,
  output logic [rot_pkg::EXT_W-1:0]     out_height_o
);

  localparam int SH = 2 * rot_pkg::FRAC_BITS;

  logic [2:0] v_q;
  logic [2:0] rdy;

  logic signed [rot_pkg::ANG_W-1:0] cos_s, sin_s;
  logic signed [rot_pkg::CRN_W-1:0] bx_s, by_s;

  // stage 1: products
  logic signed [rot_pkg::MAP_PROD_W-1:0] pxc_d, pys_d, pyc_d, pxs_d;
  logic signed [rot_pkg::MAP_PROD_W-1:0] pxc_q, pys_q, pyc_q, pxs_q;
  logic [rot_pkg::EXT_W-1:0]             ow1_q, oh1_q, ow2_q, oh2_q;
  // stage 2: sums
  logic signed [rot_pkg::SUM_W-1:0] sx_d, sy_d, sx_q, sy_q;
  // stage 3: result
  logic signed [rot_pkg::PT_W-1:0] x_t, y_t;
  logic                            hit_d;
  logic [rot_pkg::ADDR_W-1:0]      row_q, col_q;
  logic                            hit_q;
  logic [rot_pkg::EXT_W-1:0]       ow_q, oh_q;

  function automatic logic signed [rot_pkg::PT_W-1:0] trunc0(
    input logic signed [rot_pkg::SUM_W-1:0] v
  );
    logic signed [rot_pkg::PT_W-1:0] q;
    q = v[rot_pkg::SUM_W-1:SH];
    // floor plus one for a negative value with a fraction left
    if (v[rot_pkg::SUM_W-1] && (|v[SH-1:0])) q = q + rot_pkg::PT_W'(1);
    return q;
  endfunction

  assign rdy[2]    = !v_q[2] || m_ready_i;
  assign rdy[1]    = !v_q[1] || rdy[2];
  assign rdy[0]    = !v_q[0] || rdy[1];
  assign s_ready_o = rdy[0];
  assign m_valid_o = v_q[2];

  assign cos_s = $signed(cfg_i.cos_angle);
  assign sin_s = $signed(cfg_i.sin_angle);
  assign bx_s  = $signed(s_box_i.bx);
  assign by_s  = $signed(s_box_i.by);

  always_comb begin
    pxc_d = bx_s * cos_s;
    pys_d = by_s * sin_s;
    pyc_d = by_s * cos_s;
    pxs_d = bx_s * sin_s;
  end

  always_comb begin
    sx_d = rot_pkg::SUM_W'(pxc_q) + rot_pkg::SUM_W'(pys_q);
    sy_d = rot_pkg::SUM_W'(pyc_q) - rot_pkg::SUM_W'(pxs_q);
  end

  always_comb begin
    x_t   = trunc0(sx_q);
    y_t   = trunc0(sy_q);
    hit_d = !x_t[rot_pkg::PT_W-1] && !y_t[rot_pkg::PT_W-1]
            && ($unsigned(x_t) < rot_pkg::PT_W'(cfg_i.width))
            && ($unsigned(y_t) < rot_pkg::PT_W'(cfg_i.height));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= s_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && s_valid_i) begin
      pxc_q <= pxc_d;
      pys_q <= pys_d;
      pyc_q <= pyc_d;
      pxs_q <= pxs_d;
      ow1_q <= s_box_i.out_width;
      oh1_q <= s_box_i.out_height;
    end
    if (rdy[1] && v_q[0]) begin
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      ow2_q <= ow1_q;
      oh2_q <= oh1_q;
    end
    if (rdy[2] && v_q[1]) begin
      row_q <= hit_d ? y_t[rot_pkg::ADDR_W-1:0] : '0;
      col_q <= hit_d ? x_t[rot_pkg::ADDR_W-1:0] : '0;
      hit_q <= hit_d;
      ow_q  <= ow2_q;
      oh_q  <= oh2_q;
    end
  end

  assign src_row_o    = row_q;
  assign src_col_o    = col_q;
  assign hit_o        = hit_q;
  assign out_width_o  = ow_q;
  assign out_height_o = oh_q;

endmodule

// ===== src/rotate_inverse_address_map.sv =====
// Top level of the inverse-mapping address generator for nearest-neighbour image rotation.
//
// Usage: write cos and sin of the angle (signed Q2.14) and the source width and height
// through the cfg port (index 0 cos, 1 sin, 2 width, 3 height) while no request is in
// flight; only the low 13 bits of a size count, and above 4096 they read as 4096. Then
// stream destination pixels on the slave side as (row, column). For each request the master
// side returns the source row and column to fetch, a hit flag in tuser (addresses read zero
// when it is low) and the width and height of the rotated bounding box.
// Pipeline: from acceptance to the result on the master side, four stages form the box
// and the base point, then three rotate it back and test it against the source.
// Throughput: one request per cycle while tready is high, held by the seven-stage multiplier pipeline.
// Reset: returns to angle zero with a 4096 x 4096 source and empties the pipeline.
// Stall: each stage holds its request while the receiver withholds tready; empty stages
// keep filling, so the slave side still takes requests until the pipeline is full.
module rotate_inverse_address_map (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rot_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rot_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // dst_row [12:0], dst_col [25:13], zero [31:26]
  input  logic [rot_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // src_row [11:0], src_col [23:12], out_width [37:24], out_height [51:38], zero [55:52]
  output logic [rot_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // hit [0]
  output logic                                m_axis_tuser
);

  rot_pkg::cfg_t cfg_q;
  rot_pkg::box_t box;
  logic          box_valid, box_ready;
  logic [rot_pkg::DIM_W-1:0]  dim_d;
  logic [rot_pkg::ADDR_W-1:0] src_row, src_col;
  logic [rot_pkg::EXT_W-1:0]  out_width, out_height;
  logic                       hit;

  // clamp an oversized dimension at write time
  assign dim_d = (cfg_data_i[rot_pkg::DIM_W-1:0] > rot_pkg::DIM_W'(rot_pkg::MAX_DIM))
                 ? rot_pkg::DIM_W'(rot_pkg::MAX_DIM) : cfg_data_i[rot_pkg::DIM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_angle <= rot_pkg::ANG_W'(1 << rot_pkg::FRAC_BITS);
      cfg_q.sin_angle <= '0;
      cfg_q.width     <= rot_pkg::DIM_W'(rot_pkg::MAX_DIM);
      cfg_q.height    <= rot_pkg::DIM_W'(rot_pkg::MAX_DIM);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rot_pkg::CFG_COS:    cfg_q.cos_angle <= cfg_data_i;
        rot_pkg::CFG_SIN:    cfg_q.sin_angle <= cfg_data_i;
        rot_pkg::CFG_WIDTH:  cfg_q.width     <= dim_d;
        rot_pkg::CFG_HEIGHT: cfg_q.height    <= dim_d;
        default: ;
      endcase
    end
  end

  rot_box u_box (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .dst_row_i (s_axis_tdata[rot_pkg::COORD_W-1:0]),
    .dst_col_i (s_axis_tdata[2*rot_pkg::COORD_W-1:rot_pkg::COORD_W]),
    .m_valid_o (box_valid),
    .m_ready_i (box_ready),
    .m_box_o   (box)
  );

  rot_map u_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .s_valid_i    (box_valid),
    .s_ready_o    (box_ready),
    .s_box_i      (box),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .src_row_o    (src_row),
    .src_col_o    (src_col),
    .hit_o        (hit),
    .out_width_o  (out_width),
    .out_height_o (out_height)
  );

  assign m_axis_tdata = {(rot_pkg::OUT_TDATA_W - rot_pkg::OUT_FIELD_W)'(0),
                         out_height, out_width, src_col, src_row};
  assign m_axis_tuser = hit;

endmodule

// ===== src/rot_chk.sv =====
// Port-level checks on the rotation address map, bound to the top level.
module rot_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [rot_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input logic                                m_axis_tuser
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // a miss carries zero addresses
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[2*rot_pkg::ADDR_W-1:0] == '0)
    else $error("miss with nonzero source address");

  // reset leaves no result pending
  a_rst: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result presented out of reset");

  // an empty pipeline behind an idle source side stays empty
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && $past(!s_axis_tvalid, 1) && $past(!s_axis_tvalid, 2)
      && $past(!s_axis_tvalid, 3) && $past(!s_axis_tvalid, 4) && $past(!s_axis_tvalid, 5)
      && $past(!s_axis_tvalid, 6) && $past(!s_axis_tvalid, 7) && $past(!m_axis_tvalid, 7)
      && $past(rst_ni, 7)
      |=> !m_axis_tvalid)
    else $error("result without a request");

endmodule

bind rotate_inverse_address_map rot_chk u_rot_chk (.*);
